// File: hw/rtl/mcw_pkg.sv
// ---------------------------------------------------------------------------
// mcw_pkg: shared constants for the minimum covering window block
// Opcode values of the request channel and default buffer sizes.
// ---------------------------------------------------------------------------
`default_nettype none

package mcw_pkg;

	localparam int unsigned MCW_MAX_TEXT    = 4096;
	localparam int unsigned MCW_MAX_PATTERN = 4096;

	localparam logic [1:0] OP_PATTERN = 2'd0;
	localparam logic [1:0] OP_TEXT    = 2'd1;
	localparam logic [1:0] OP_FINISH  = 2'd2;

endpackage

`default_nettype wire

// File: hw/rtl/mcw_ram.sv
// ---------------------------------------------------------------------------
// mcw_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
`default_nettype none

module mcw_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/minimum_covering_window.sv
// ---------------------------------------------------------------------------
// minimum_covering_window: shortest text window covering a byte pattern
// Sliding-window search over a stored text with per-byte need counts.
// ---------------------------------------------------------------------------
// A job is a run of requests: pattern bytes (opcode 0), then text bytes
// (opcode 1), then one finish request (opcode 2), which is the only request
// that produces a result. The result carries found, the start and length of
// the shortest window of the text that holds every pattern byte at least as
// often as the pattern does (the earliest among equal lengths), and an
// overflow flag that is set when pattern or text bytes were dropped because
// the buffers were full. The finish request also clears the job, so the next
// request starts a new one. Pattern bytes that arrive after the first text
// byte of a job are ignored, as is opcode 3. An empty pattern reports not
// found. The block works on one request at a time. A pattern byte has its
// need count read and written back; a finish completes as it is accepted.
// A text byte has its need count read and written back and the window is
// then tested; for every position the window start moves forward, the
// block reads the text byte at the start, reads its need count, writes it
// back and tests again. The start moves at most once per stored text byte;
// the dependent chain of text read, need-count read and write back limits
// the pace. Need counts are cleared at once on reset and on finish through
// a valid bit per entry, so no clearing pass is needed. Requests wait while
// the block is busy; a finish request also waits while an earlier result
// has not been taken; other requests are accepted while a result waits.
// ---------------------------------------------------------------------------
`default_nettype none

module minimum_covering_window
	import mcw_pkg::*;
#(
	parameter int unsigned MAX_TEXT    = MCW_MAX_TEXT,
	parameter int unsigned MAX_PATTERN = MCW_MAX_PATTERN,
	localparam int unsigned PW = $clog2(MAX_TEXT),
	localparam int unsigned LW = $clog2(MAX_TEXT + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [1:0]    opcode,
	input  wire logic [7:0]    symbol,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic               found,
	output logic      [PW-1:0] window_start,
	output logic      [LW-1:0] window_length,
	output logic               overflow
);

	// Need counts swing from +MAX_PATTERN down to -MAX_TEXT, plus a sign bit.
	localparam int unsigned MAXC = (MAX_PATTERN > MAX_TEXT) ? MAX_PATTERN : MAX_TEXT;
	localparam int unsigned NW   = $clog2(MAXC + 1) + 1;
	localparam int unsigned CW   = $clog2(MAX_PATTERN + 1);

	// Sequencer states.
	localparam logic [2:0] ST_IDLE = 3'd0; // accept a request
	localparam logic [2:0] ST_PAT  = 3'd1; // write back need count of a pattern byte
	localparam logic [2:0] ST_TXT  = 3'd2; // write back need count of a text byte
	localparam logic [2:0] ST_CHK  = 3'd3; // test whether the window still covers
	localparam logic [2:0] ST_TRD  = 3'd4; // text byte at the window start is ready
	localparam logic [2:0] ST_NRD  = 3'd5; // write back need count of the dropped byte

	logic [2:0]    state_q;
	logic [255:0]  nvalid_q;      // need-count entry written in this job
	logic [7:0]    naddr_q;       // need-count entry being updated
	logic [8:0]    distinct_q;    // distinct pattern bytes still owed
	logic [LW-1:0] head_q;        // text bytes stored
	logic [LW-1:0] tail_q;        // window start
	logic [CW-1:0] plen_q;        // pattern bytes accepted
	logic          best_valid_q;
	logic [PW-1:0] best_start_q;
	logic [LW-1:0] best_len_q;
	logic          ovf_q;

	logic          out_valid_q;
	logic          found_q;
	logic [PW-1:0] start_q;
	logic [LW-1:0] length_q;
	logic          overflow_q;

	// Memory ports.
	logic                 need_we;
	logic        [7:0]    need_raddr;
	logic                 need_re;
	logic signed [NW-1:0] need_wdata;
	logic signed [NW-1:0] need_rdata;
	logic                 text_we;
	logic                 text_re;
	logic        [7:0]    text_rdata;

	logic                 accept;
	logic signed [NW-1:0] need_cur;
	logic signed [NW-1:0] need_inc;
	logic signed [NW-1:0] need_dec;
	logic                 covering;
	logic        [LW-1:0] win_len;

	assign accept = in_valid && in_ready;

	// A finish may only load the output register once it is free.
	assign in_ready = (state_q == ST_IDLE) &&
		(!out_valid_q || out_ready || (opcode != OP_FINISH));

	// Entries not yet written in this job read as zero.
	assign need_cur = nvalid_q[naddr_q] ? need_rdata : '0;
	assign need_inc = need_cur + NW'(1);
	assign need_dec = need_cur - NW'(1);

	assign covering = (plen_q != '0) && (distinct_q == '0) && (tail_q < head_q);
	assign win_len  = head_q - tail_q;

	always_comb begin
		need_re    = 1'b0;
		need_raddr = symbol;
		need_we    = 1'b0;
		need_wdata = need_inc;
		text_we    = 1'b0;
		text_re    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && (opcode == OP_PATTERN) && (head_q == '0) &&
					(plen_q != CW'(MAX_PATTERN))) begin
					need_re = 1'b1;
				end
				if (accept && (opcode == OP_TEXT) && (head_q != LW'(MAX_TEXT))) begin
					need_re = 1'b1;
					text_we = 1'b1;
				end
			end
			ST_PAT: begin
				need_we = 1'b1;
			end
			ST_TXT: begin
				need_we    = 1'b1;
				need_wdata = need_dec;
			end
			ST_CHK: begin
				text_re = covering;
			end
			ST_TRD: begin
				need_re    = 1'b1;
				need_raddr = text_rdata;
			end
			ST_NRD: begin
				need_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	mcw_ram #(
		.WIDTH(NW),
		.DEPTH(256)
	) u_need_ram (
		.clk   (clk),
		.we    (need_we),
		.waddr (naddr_q),
		.wdata (need_wdata),
		.re    (need_re),
		.raddr (need_raddr),
		.rdata (need_rdata)
	);

	mcw_ram #(
		.WIDTH(8),
		.DEPTH(MAX_TEXT)
	) u_text_ram (
		.clk   (clk),
		.we    (text_we),
		.waddr (head_q[PW-1:0]),
		.wdata (symbol),
		.re    (text_re),
		.raddr (tail_q[PW-1:0]),
		.rdata (text_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			nvalid_q     <= '0;
			naddr_q      <= '0;
			distinct_q   <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			plen_q       <= '0;
			best_valid_q <= 1'b0;
			best_start_q <= '0;
			best_len_q   <= '0;
			ovf_q        <= 1'b0;
		end else begin
			if (need_we) begin
				nvalid_q[naddr_q] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (opcode)
							OP_PATTERN: begin
								if (head_q == '0) begin
									if (plen_q == CW'(MAX_PATTERN)) begin
										ovf_q <= 1'b1;
									end else begin
										naddr_q <= symbol;
										state_q <= ST_PAT;
									end
								end
							end
							OP_TEXT: begin
								if (head_q == LW'(MAX_TEXT)) begin
									ovf_q <= 1'b1;
								end else begin
									naddr_q <= symbol;
									head_q  <= head_q + LW'(1);
									state_q <= ST_TXT;
								end
							end
							OP_FINISH: begin
								// The result is loaded below; start a fresh job.
								nvalid_q     <= '0;
								distinct_q   <= '0;
								head_q       <= '0;
								tail_q       <= '0;
								plen_q       <= '0;
								best_valid_q <= 1'b0;
								best_start_q <= '0;
								ovf_q        <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_PAT: begin
					plen_q <= plen_q + CW'(1);
					if (need_cur == '0) begin
						distinct_q <= distinct_q + 9'd1;
					end
					state_q <= ST_IDLE;
				end
				ST_TXT: begin
					if (need_dec == '0) begin
						distinct_q <= distinct_q - 9'd1;
					end
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (covering) begin
						if (!best_valid_q || (win_len < best_len_q)) begin
							best_valid_q <= 1'b1;
							best_len_q   <= win_len;
							best_start_q <= tail_q[PW-1:0];
						end
						state_q <= ST_TRD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_TRD: begin
					naddr_q <= text_rdata;
					state_q <= ST_NRD;
				end
				ST_NRD: begin
					if (need_inc == NW'(1)) begin
						distinct_q <= distinct_q + 9'd1;
					end
					tail_q  <= tail_q + LW'(1);
					state_q <= ST_CHK;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result handshake: a finish fills the output register, the sink empties it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && (opcode == OP_FINISH)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload; only loaded on a finish request.
	always_ff @(posedge clk) begin
		if (accept && (opcode == OP_FINISH)) begin
			found_q    <= (plen_q != '0) && best_valid_q;
			start_q    <= ((plen_q != '0) && best_valid_q) ? best_start_q : '0;
			length_q   <= ((plen_q != '0) && best_valid_q) ? best_len_q : '0;
			overflow_q <= ovf_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign found         = found_q;
	assign window_start  = start_q;
	assign window_length = length_q;
	assign overflow      = overflow_q;

endmodule

`default_nettype wire
